/* hw/rtl/glt_pkg.sv */
// Shared types, constants and font tables for the glyph text layout block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package glt_pkg;

    // Fixed widths of the request and result fields.
    localparam int POS_W       = 16;
    localparam int CLIP_X_W    = 7;
    localparam int CLIP_Y_W    = 5;
    localparam int SIZE_W      = 16;
    localparam int CODE_W      = 8;
    localparam int GLYPH_W     = 6;
    localparam int ADV_W       = 3;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    // Default coordinate width of the cursor.
    localparam int COORD_BITS_DEF = 16;

    // Font geometry.
    localparam int MAP_SIZE    = 96;
    localparam int GLYPH_COUNT = 44;
    localparam int FONT_COLS   = 13;
    localparam int FONT_ROWS   = 4;
    localparam int CELL_W      = 5;
    localparam int CELL_H      = 5;
    localparam int LINE_ADV    = 4;
    localparam int ULINE_LEFT  = (FONT_COLS - 1) * CELL_W;

    localparam logic [CODE_W-1:0]  CODE_NEWLINE = 8'd10;
    localparam logic [GLYPH_W-1:0] NO_GLYPH     = 6'd63;
    localparam logic [1:0]         SKIN_INVALID = 2'd3;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_GLYPH = 2'd0,
        KIND_ULINE = 2'd1,
        KIND_SIZE  = 2'd2
    } kind_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_ORIGIN_X  = 2'd0,
        REG_ORIGIN_Y  = 2'd1,
        REG_SKIN      = 2'd2,
        REG_UNDERLINE = 2'd3
    } reg_idx_t;

    // Configuration as seen by the layout datapath.
    typedef struct packed {
        logic signed [POS_W-1:0] origin_x;
        logic signed [POS_W-1:0] origin_y;
        logic [1:0]              skin_select;
        logic                    underline_enable;
    } cfg_t;

    // One result item.
    typedef struct packed {
        kind_t                   kind;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic [CLIP_X_W-1:0]     clip_left;
        logic [CLIP_Y_W-1:0]     clip_bottom;
        logic [CLIP_X_W-1:0]     clip_right;
        logic [CLIP_Y_W-1:0]     clip_top;
        logic [SIZE_W-1:0]       text_width;
        logic [SIZE_W-1:0]       text_height;
        logic                    last;
    } res_t;

    // The results of one request: one or two items.
    typedef struct packed {
        logic two;
        res_t first;
        res_t second;
    } pair_t;

    // Character code to glyph index; NO_GLYPH marks codes without a glyph.
    localparam logic [GLYPH_W-1:0] CODE_MAP [MAP_SIZE] = '{
        6'd63, 6'd39, 6'd40, 6'd41, 6'd42, 6'd43, 6'd63, 6'd63,
        6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63,
        6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63,
        6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63,
        6'd36, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63,
        6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd37, 6'd63,
        6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd33,
        6'd34, 6'd35, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd38,
        6'd63, 6'd0,  6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd6,
        6'd7,  6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13, 6'd14,
        6'd15, 6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd22,
        6'd23, 6'd24, 6'd25, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63
    };

    // Horizontal advance of each glyph.
    localparam logic [ADV_W-1:0] ADV_TABLE [GLYPH_COUNT] = '{
        3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd2, 3'd3, 3'd3,
        3'd3, 3'd4, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
        3'd4, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
        3'd3, 3'd3, 3'd4, 3'd2, 3'd3, 3'd4, 3'd3, 3'd3, 3'd4, 3'd4, 3'd3
    };

endpackage

/* hw/rtl/glyph_text_layout.sv */
// Top level of the glyph text layout block.
// Instantiates glt_cfg, glt_layout and glt_out; uses glt_pkg.
//
// Usage:
// A request (char_code, end_of_text) enters on in_valid/in_ready and is
// held in an input register. From there the layout logic decodes
// it against the cursor state, updates the state and loads its results,
// one glyph command plus an optional underline command, or one size report,
// into a result register. That register is presented on out_valid/out_ready,
// with last high on the final result of the request.
// Throughput: one request per cycle while the receiver takes results, for
// requests with no result or one result; a glyph with underline holds the
// output until both its results are taken, the single result port being
// the limit. A new request is accepted while a finished result still waits
// to be taken. When the receiver stalls, the result register holds;
// requests that make no result still proceed, others wait in the input
// register and then in_ready drops.
// Reset clears the configuration, puts the cursor at the origin, clears
// the line sums and empties both registers; no clearing pass is needed.
// The user must write configuration through the APB port while the block
// is idle; the block itself leaves this rule to the user.
`timescale 1ns / 1ps

module glyph_text_layout
    import glt_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    // Configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [APB_ADDR_W-1:0]      paddr,
    input  logic [APB_DATA_W-1:0]      pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready,
    // Request channel
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [CODE_W-1:0]          char_code,
    input  logic                       end_of_text,
    // Result channel
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [1:0]                 kind,
    output logic signed [POS_W-1:0]    pos_x,
    output logic signed [POS_W-1:0]    pos_y,
    output logic [CLIP_X_W-1:0]        clip_left,
    output logic [CLIP_Y_W-1:0]        clip_bottom,
    output logic [CLIP_X_W-1:0]        clip_right,
    output logic [CLIP_Y_W-1:0]        clip_top,
    output logic [SIZE_W-1:0]          text_width,
    output logic [SIZE_W-1:0]          text_height,
    output logic                       last
);

    cfg_t  cfg;
    logic  pair_valid;
    pair_t pair;
    logic  pair_pop;
    res_t  res;

    glt_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    glt_layout #(
        .COORD_BITS (COORD_BITS)
    ) u_layout (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .char_code   (char_code),
        .end_of_text (end_of_text),
        .pair_valid  (pair_valid),
        .pair        (pair),
        .pair_pop    (pair_pop)
    );

    glt_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .pair_valid (pair_valid),
        .pair       (pair),
        .pair_pop   (pair_pop),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .res        (res)
    );

    // Result fields onto the ports.
    assign kind        = res.kind;
    assign pos_x       = res.pos_x;
    assign pos_y       = res.pos_y;
    assign clip_left   = res.clip_left;
    assign clip_bottom = res.clip_bottom;
    assign clip_right  = res.clip_right;
    assign clip_top    = res.clip_top;
    assign text_width  = res.text_width;
    assign text_height = res.text_height;
    assign last        = res.last;

endmodule

/* hw/rtl/glt_cfg.sv */
// APB-style configuration registers of the glyph text layout block.
// Depends on glt_pkg for the register indexes and the configuration struct.
`timescale 1ns / 1ps

module glt_cfg
    import glt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic signed [POS_W-1:0] origin_x_reg;
    logic signed [POS_W-1:0] origin_y_reg;
    logic [1:0]              skin_reg;
    logic                    underline_reg;
    logic                    wr_en;
    reg_idx_t                reg_idx;

    // Registers are word aligned; the low address bits are ignored.
    assign reg_idx = reg_idx_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Register writes during the access phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg  <= '0;
            origin_y_reg  <= '0;
            skin_reg      <= '0;
            underline_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_ORIGIN_X:  origin_x_reg  <= pwdata[POS_W-1:0];
                REG_ORIGIN_Y:  origin_y_reg  <= pwdata[POS_W-1:0];
                REG_SKIN:      skin_reg      <= pwdata[1:0];
                REG_UNDERLINE: underline_reg <= pwdata[0];
            endcase
        end
    end

    // Read back; the origins are returned sign extended.
    always_comb
    begin
        unique case (reg_idx)
            REG_ORIGIN_X:  prdata = APB_DATA_W'(origin_x_reg);
            REG_ORIGIN_Y:  prdata = APB_DATA_W'(origin_y_reg);
            REG_SKIN:      prdata = APB_DATA_W'(skin_reg);
            REG_UNDERLINE: prdata = APB_DATA_W'(underline_reg);
        endcase
    end

    assign cfg.origin_x         = origin_x_reg;
    assign cfg.origin_y         = origin_y_reg;
    assign cfg.skin_select      = skin_reg;
    assign cfg.underline_enable = underline_reg;

endmodule

/* hw/rtl/glt_layout.sv */
// Layout datapath: input register, cursor and size state, and the result
// register that holds the one or two results of a request. Uses glt_pkg.
`timescale 1ns / 1ps

module glt_layout
    import glt_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [CODE_W-1:0] char_code,
    input  logic              end_of_text,
    output logic              pair_valid,
    output pair_t             pair,
    input  logic              pair_pop
);

    // Wide enough to hold a 16-bit origin or a cursor plus a small step.
    localparam int EXT_W = ((COORD_BITS > POS_W) ? COORD_BITS : POS_W) + 2;
    localparam logic signed [EXT_W-1:0] CMAX =
        EXT_W'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
    localparam logic signed [EXT_W-1:0] CMIN = -CMAX - EXT_W'(1);
    localparam logic signed [EXT_W-1:0] LINE_STEP = EXT_W'(LINE_ADV);
    localparam logic signed [EXT_W-1:0] ONE_STEP  = EXT_W'(1);

    function automatic logic signed [COORD_BITS-1:0] sat_coord(
        input logic signed [EXT_W-1:0] v
    );
        logic signed [EXT_W-1:0] c;
        c = v;
        if (v > CMAX)
            c = CMAX;
        else if (v < CMIN)
            c = CMIN;
        return COORD_BITS'(c);
    endfunction

    // Input register.
    logic              in_valid_reg;
    logic [CODE_W-1:0] code_reg;
    logic              eot_reg;

    // Layout state.
    logic signed [COORD_BITS-1:0] cursor_x_reg, cursor_x_next;
    logic signed [COORD_BITS-1:0] cursor_y_reg, cursor_y_next;
    logic [SIZE_W-1:0]            line_adv_reg, line_adv_next;
    logic [SIZE_W-1:0]            widest_reg, widest_next;
    logic [SIZE_W-1:0]            height_reg, height_next;

    // Result register.
    logic  pair_valid_reg;
    pair_t pair_reg, pair_next;

    // Decode and arithmetic.
    logic signed [POS_W-1:0]      org_x, org_y;
    logic signed [COORD_BITS-1:0] org_x_sat, org_y_sat;
    logic                         code_in_map, has_glyph, is_newline;
    logic [GLYPH_W-1:0]           glyph;
    logic [ADV_W-1:0]             adv;
    logic [1:0]                   row;
    logic [GLYPH_W-1:0]           col_full;
    logic [3:0]                   col;
    logic                         do_eot, do_nl, do_glyph, emit_glyph, produces;
    logic                         launch, pair_can_load;
    logic signed [EXT_W-1:0]      adv_ext;
    logic [SIZE_W:0]              line_sum, height_sum;
    logic [SIZE_W-1:0]            line_max;

    assign org_x     = cfg.origin_x;
    assign org_y     = cfg.origin_y;
    assign org_x_sat = sat_coord(EXT_W'(org_x));
    assign org_y_sat = sat_coord(EXT_W'(org_y));

    // Font lookup: glyph index, advance and atlas cell.
    always_comb
    begin
        code_in_map = code_reg < CODE_W'(MAP_SIZE);
        glyph       = code_in_map ? CODE_MAP[code_reg[6:0]] : NO_GLYPH;
        has_glyph   = glyph < GLYPH_W'(GLYPH_COUNT);
        adv         = has_glyph ? ADV_TABLE[glyph] : '0;
        if (glyph >= GLYPH_W'(3 * FONT_COLS))
            row = 2'd3;
        else if (glyph >= GLYPH_W'(2 * FONT_COLS))
            row = 2'd2;
        else if (glyph >= GLYPH_W'(FONT_COLS))
            row = 2'd1;
        else
            row = 2'd0;
        col_full = glyph - GLYPH_W'(row) * GLYPH_W'(FONT_COLS);
        col      = col_full[3:0];
    end

    // Request classification and handshake.
    assign is_newline    = code_reg == CODE_NEWLINE;
    assign do_eot        = eot_reg;
    assign do_nl         = !eot_reg && is_newline;
    assign do_glyph      = !eot_reg && !is_newline && has_glyph;
    assign emit_glyph    = do_glyph && (cfg.skin_select != SKIN_INVALID);
    assign produces      = do_eot || emit_glyph;
    assign pair_can_load = !pair_valid_reg || pair_pop;
    assign launch        = in_valid_reg && (!produces || pair_can_load);
    assign in_ready      = !in_valid_reg || launch;

    assign adv_ext    = EXT_W'(adv);
    assign line_sum   = (SIZE_W + 1)'(line_adv_reg) + (SIZE_W + 1)'(adv);
    assign height_sum = (SIZE_W + 1)'(height_reg) + (SIZE_W + 1)'(LINE_ADV);
    assign line_max   = (line_adv_reg > widest_reg) ? line_adv_reg : widest_reg;

    // Next layout state.
    always_comb
    begin
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        line_adv_next = line_adv_reg;
        widest_next   = widest_reg;
        height_next   = height_reg;
        if (launch)
        begin
            if (do_eot)
            begin
                cursor_x_next = org_x_sat;
                cursor_y_next = org_y_sat;
                line_adv_next = '0;
                widest_next   = '0;
                height_next   = SIZE_W'(LINE_ADV);
            end
            else if (do_nl)
            begin
                widest_next   = line_max;
                line_adv_next = '0;
                height_next   = height_sum[SIZE_W] ? '1 : height_sum[SIZE_W-1:0];
                cursor_x_next = org_x_sat;
                cursor_y_next = sat_coord(EXT_W'(cursor_y_reg) - LINE_STEP);
            end
            else if (do_glyph)
            begin
                cursor_x_next = sat_coord(EXT_W'(cursor_x_reg) + adv_ext);
                line_adv_next = line_sum[SIZE_W] ? '1 : line_sum[SIZE_W-1:0];
            end
        end
    end

    // Results of the request in the input register.
    always_comb
    begin
        pair_next = '0;
        if (do_eot)
        begin
            pair_next.first.kind        = KIND_SIZE;
            pair_next.first.text_width  = line_max;
            pair_next.first.text_height = height_reg;
            pair_next.first.last        = 1'b1;
        end
        else
        begin
            pair_next.two               = cfg.underline_enable;
            pair_next.first.kind        = KIND_GLYPH;
            pair_next.first.pos_x       = POS_W'(cursor_x_reg);
            pair_next.first.pos_y       = POS_W'(cursor_y_reg);
            pair_next.first.clip_left   = CLIP_X_W'(col) * CLIP_X_W'(CELL_W);
            pair_next.first.clip_right  = CLIP_X_W'(col) * CLIP_X_W'(CELL_W)
                                          + CLIP_X_W'(CELL_W);
            pair_next.first.clip_bottom = CLIP_Y_W'(2'd3 - row) * CLIP_Y_W'(CELL_H);
            pair_next.first.clip_top    = CLIP_Y_W'(2'd3 - row) * CLIP_Y_W'(CELL_H)
                                          + CLIP_Y_W'(CELL_H);
            pair_next.first.last        = !cfg.underline_enable;
            pair_next.second.kind        = KIND_ULINE;
            pair_next.second.pos_x       = POS_W'(cursor_x_reg);
            pair_next.second.pos_y       =
                POS_W'(sat_coord(EXT_W'(cursor_y_reg) - ONE_STEP));
            pair_next.second.clip_left   = CLIP_X_W'(ULINE_LEFT);
            pair_next.second.clip_bottom = '0;
            pair_next.second.clip_right  = CLIP_X_W'(ULINE_LEFT + 1) + CLIP_X_W'(adv);
            pair_next.second.clip_top    = CLIP_Y_W'(1);
            pair_next.second.last        = 1'b1;
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            code_reg <= char_code;
            eot_reg  <= end_of_text;
        end
    end

    // Layout state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg <= '0;
            cursor_y_reg <= '0;
            line_adv_reg <= '0;
            widest_reg   <= '0;
            height_reg   <= SIZE_W'(LINE_ADV);
        end
        else
        begin
            cursor_x_reg <= cursor_x_next;
            cursor_y_reg <= cursor_y_next;
            line_adv_reg <= line_adv_next;
            widest_reg   <= widest_next;
            height_reg   <= height_next;
        end
    end

    // Result register: loaded by a request that produces results.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pair_valid_reg <= 1'b0;
        else if (launch && produces)
            pair_valid_reg <= 1'b1;
        else if (pair_pop)
            pair_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (launch && produces)
            pair_reg <= pair_next;
    end

    assign pair_valid = pair_valid_reg;
    assign pair       = pair_reg;

endmodule

/* hw/rtl/glt_out.sv */
// Output stage: presents the one or two results held in the result
// register one at a time on the valid/ready channel. Uses glt_pkg.
`timescale 1ns / 1ps

module glt_out
    import glt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  pair_valid,
    input  pair_t pair,
    output logic  pair_pop,
    input  logic  out_ready,
    output logic  out_valid,
    output res_t  res
);

    logic sel_reg, sel_next;
    logic out_take;

    assign out_valid = pair_valid;
    assign res       = sel_reg ? pair.second : pair.first;
    assign out_take  = pair_valid && out_ready;
    assign pair_pop  = out_take && (sel_reg || !pair.two);

    // Step to the second result, or back to the first once the pair leaves.
    always_comb
    begin
        sel_next = sel_reg;
        if (pair_pop)
            sel_next = 1'b0;
        else if (out_take)
            sel_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sel_reg <= 1'b0;
        else
            sel_reg <= sel_next;
    end

endmodule

/* hw/rtl/glt_checker.sv */
// Port-level checks of the glyph text layout block, bound to the top level.
// Depends on glt_pkg for the result kinds and field widths.
`timescale 1ns / 1ps

module glt_checker
    import glt_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic [1:0]              kind,
    input logic signed [POS_W-1:0] pos_x,
    input logic [CLIP_X_W-1:0]     clip_left,
    input logic [CLIP_Y_W-1:0]     clip_bottom,
    input logic [CLIP_Y_W-1:0]     clip_top,
    input logic                    last
);

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

    // A glyph that is not last is followed at once by its underline.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && kind == KIND_GLYPH && !last
        |=> out_valid && kind == KIND_ULINE)
    else $error("underline does not follow its glyph");

    // Size reports and underlines always close their request.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_SIZE || kind == KIND_ULINE) |-> last)
    else $error("size report or underline without last");

    // An underline strip always uses the fixed atlas row.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_ULINE
        |-> clip_left == CLIP_X_W'(ULINE_LEFT) && clip_bottom == '0
            && clip_top == CLIP_Y_W'(1))
    else $error("underline clip rectangle malformed");

    // A size report carries no position.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_SIZE |-> pos_x == '0 && clip_left == '0)
    else $error("size report with position data");

endmodule

bind glyph_text_layout glt_checker u_glt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .pos_x       (pos_x),
    .clip_left   (clip_left),
    .clip_bottom (clip_bottom),
    .clip_top    (clip_top),
    .last        (last)
);
